// File: hw/rtl/gossip_membership_table_assert.svh
// Assertion macros for the membership table checker.
`ifndef GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH
`define GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH

// Implication into the next cycle, off during reset.
`define GMT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("membership table: next-cycle check failed");

// Implication in the same cycle, off during reset.
`define GMT_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("membership table: same-cycle check failed");

// State in the cycle after reset.
`define GMT_ASSERT_RESET(label, post) \
   label: assert property (@(posedge clock) reset |=> (post)) \
      else $error("membership table: reset check failed");

`endif

// File: hw/rtl/gmt_pkg.sv
package gmt_pkg;

   localparam int NODES_DEFAULT = 16;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 31;

   localparam logic [CSR_DW-1:0] SUSPECT_RESET = 31'd1500;
   localparam logic [CSR_DW-1:0] DEAD_RESET = 31'd4000;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_BEAT  = 3'd2;
   localparam logic [2:0] OP_MERGE = 3'd3;
   localparam logic [2:0] OP_CHECK = 3'd4;
   localparam logic [2:0] OP_QUERY = 3'd5;
   localparam logic [2:0] OP_SNAP  = 3'd6;
   localparam logic [2:0] OP_NOP   = 3'd7;

   localparam logic [CSR_IW-1:0] REG_SELF    = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SUSPECT = 2'd1;
   localparam logic [CSR_IW-1:0] REG_DEAD    = 2'd2;

   localparam logic [1:0] STATUS_ALIVE   = 2'd0;
   localparam logic [1:0] STATUS_SUSPECT = 2'd1;
   localparam logic [1:0] STATUS_DEAD    = 2'd2;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  node;
      logic [47:0] remote_epoch;
      logic [31:0] remote_heartbeat;
   } req_type;

   typedef struct packed {
      logic [3:0]  entry_node;
      logic        present;
      logic [1:0]  node_status;
      logic [47:0] entry_epoch;
      logic [31:0] entry_heartbeat;
      logic        is_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] epoch;
      logic [31:0] beat;
      logic [31:0] last_seen;
   } entry_type;

endpackage

// File: hw/rtl/gmt_ram.sv
module gmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gossip_membership_table.sv
// Gossip membership table with heartbeat failure detection.
// Items enter on req_item when start is high and busy is low. The user must
// write configuration registers (self node, suspect and dead timeouts) via
// csr_we / csr_index / csr_wdata while idle; the block does not enforce it.
// Results leave on rsp_item, each shown for one cycle with rsp_valid; the
// receiver cannot stall, so the block never waits on the result side.
// A tick item or an unused op finishes at the accepting edge; busy stays low.
// Add, heartbeat, merge and query hold busy through a read state, which
// reads the entry RAM (registered read), and an exec state, which
// updates it or forms the result. A query result is registered from exec.
// Timeout checks and snapshots walk every entry, each through the read and
// exec states, so busy stays high for the whole walk; snapshot results come
// at most one per entry, the final one flagged by is_last.
// The shared RAM address and the per-entry compare unit set this stepping.
// Reset clears all present bits, the tick counter and the registers to
// their defaults; entry contents need no clearing.
module gossip_membership_table #(
   parameter int NODES = gmt_pkg::NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  gmt_pkg::req_type              req_item,
   output logic                          rsp_valid,
   output gmt_pkg::rsp_type              rsp_item,
   input  logic                          csr_we,
   input  logic [gmt_pkg::CSR_IW-1:0]    csr_index,
   input  logic [gmt_pkg::CSR_DW-1:0]    csr_wdata
);

   import gmt_pkg::*;

   localparam int IW = $clog2(NODES);
   localparam int CW = ((IW > 4) ? IW : 4) + 1;
   localparam logic [IW-1:0] IDX_LAST = IW'(NODES - 1);

   fsm_type             fsm_ff, fsm_in;
   req_type             item_ff, item_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [4:0]          sent_ff, sent_in;
   logic [NODES-1:0]    present_ff, present_in;
   logic [31:0]         time_ff, time_in;
   logic [3:0]          self_ff, self_in;
   logic [CSR_DW-1:0]   suspect_ff, suspect_in;
   logic [CSR_DW-1:0]   dead_ff, dead_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                ram_we;
   entry_type           ram_wr_data;
   entry_type           ram_rd_data;

   logic                node_ok;
   logic                self_ok;
   logic                idx_ok;
   logic                cur_present;
   logic                query_hit;
   logic                more_above;
   logic                newer;
   logic [31:0]         elapsed;
   logic [31:0]         base_beat;
   logic [47:0]         base_epoch;
   logic [1:0]          new_status;

   gmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NODES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         present_ff   <= '0;
         time_ff      <= '0;
         self_ff      <= '0;
         suspect_ff   <= SUSPECT_RESET;
         dead_ff      <= DEAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         present_ff   <= present_in;
         time_ff      <= time_in;
         self_ff      <= self_in;
         suspect_ff   <= suspect_in;
         dead_ff      <= dead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      sent_ff <= sent_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      self_in    = self_ff;
      suspect_in = suspect_ff;
      dead_in    = dead_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SELF:    self_in    = csr_wdata[3:0];
            REG_SUSPECT: suspect_in = csr_wdata;
            REG_DEAD:    dead_in    = csr_wdata;
            default:     self_in    = self_ff;
         endcase
      end
   end

   assign node_ok     = CW'(item_ff.node) < CW'(NODES);
   assign self_ok     = CW'(self_ff) < CW'(NODES);
   assign idx_ok      = CW'(idx_ff) < CW'(NODES);
   assign cur_present = idx_ok && present_ff[idx_ff];
   assign query_hit   = node_ok && cur_present;

   always_comb begin
      more_above = 1'b0;
      for (int j = 0; j < NODES; j++) begin
         if (present_ff[j] && (CW'(j) > CW'(idx_ff))) begin
            more_above = 1'b1;
         end
      end
   end

   assign newer      = {ram_rd_data.epoch, ram_rd_data.beat}
                       < {item_ff.remote_epoch, item_ff.remote_heartbeat};
   assign elapsed    = time_ff - ram_rd_data.last_seen;
   assign base_beat  = cur_present ? ram_rd_data.beat : 32'd0;
   assign base_epoch = cur_present ? ram_rd_data.epoch : 48'd0;

   always_comb begin
      if (elapsed > {1'b0, dead_ff}) begin
         new_status = STATUS_DEAD;
      end else if (elapsed > {1'b0, suspect_ff}) begin
         new_status = STATUS_SUSPECT;
      end else begin
         new_status = STATUS_ALIVE;
      end
   end

   always_comb begin
      fsm_in       = fsm_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      sent_in      = sent_ff;
      present_in   = present_ff;
      time_in      = time_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_wr_data  = '{status: STATUS_ALIVE, epoch: item_ff.remote_epoch,
                       beat: item_ff.remote_heartbeat, last_seen: time_ff};
      case (fsm_ff)
         FSM_IDLE: begin
            if (start) begin
               item_in = req_item;
               case (req_item.op)
                  OP_TICK: time_in = time_ff + 32'd1;
                  OP_CHECK, OP_SNAP: begin
                     idx_in  = '0;
                     sent_in = '0;
                     fsm_in  = FSM_READ;
                  end
                  OP_BEAT: begin
                     idx_in = IW'(self_ff);
                     fsm_in = FSM_READ;
                  end
                  OP_ADD, OP_MERGE, OP_QUERY: begin
                     idx_in = IW'(req_item.node);
                     fsm_in = FSM_READ;
                  end
                  default: fsm_in = FSM_IDLE;
               endcase
            end
         end
         FSM_READ: begin
            fsm_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            fsm_in = FSM_IDLE;
            case (item_ff.op)
               OP_ADD: begin
                  if (node_ok) begin
                     ram_we      = 1'b1;
                     ram_wr_data = '{status: STATUS_ALIVE, epoch: 48'd0, beat: 32'd0,
                                     last_seen: time_ff};
                     present_in[idx_ff] = 1'b1;
                  end
               end
               OP_BEAT: begin
                  if (self_ok) begin
                     ram_we      = 1'b1;
                     ram_wr_data = '{status: STATUS_ALIVE, epoch: base_epoch,
                                     beat: (&base_beat) ? base_beat : base_beat + 32'd1,
                                     last_seen: time_ff};
                     present_in[idx_ff] = 1'b1;
                  end
               end
               OP_MERGE: begin
                  if (node_ok && (item_ff.node != self_ff) && (!cur_present || newer)) begin
                     ram_we = 1'b1;
                     present_in[idx_ff] = 1'b1;
                  end
               end
               OP_CHECK: begin
                  if (cur_present && (CW'(idx_ff) != CW'(self_ff))) begin
                     ram_we      = 1'b1;
                     ram_wr_data = '{status: new_status, epoch: ram_rd_data.epoch,
                                     beat: ram_rd_data.beat,
                                     last_seen: ram_rd_data.last_seen};
                  end
                  if (idx_ff != IDX_LAST) begin
                     idx_in = idx_ff + 1'b1;
                     fsm_in = FSM_READ;
                  end
               end
               OP_QUERY: begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{entry_node: item_ff.node, present: query_hit,
                             node_status: query_hit ? ram_rd_data.status : 2'd0,
                             entry_epoch: query_hit ? ram_rd_data.epoch : 48'd0,
                             entry_heartbeat: query_hit ? ram_rd_data.beat : 32'd0,
                             is_last: 1'b1};
               end
               OP_SNAP: begin
                  if (cur_present && !sent_ff[4]) begin
                     rsp_valid_in = 1'b1;
                     sent_in      = sent_ff + 5'd1;
                     rsp_in = '{entry_node: 4'(idx_ff), present: 1'b1,
                                node_status: ram_rd_data.status,
                                entry_epoch: ram_rd_data.epoch,
                                entry_heartbeat: ram_rd_data.beat,
                                is_last: !more_above || (&sent_ff[3:0])};
                  end
                  if (idx_ff != IDX_LAST) begin
                     idx_in = idx_ff + 1'b1;
                     fsm_in = FSM_READ;
                  end
               end
               default: fsm_in = FSM_IDLE;
            endcase
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   assign busy      = (fsm_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: hw/rtl/gmt_checker.sv
`include "gossip_membership_table_assert.svh"

module gmt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input gmt_pkg::req_type           req_item,
   input logic                       rsp_valid,
   input gmt_pkg::rsp_type           rsp_item,
   input logic                       csr_we,
   input logic [gmt_pkg::CSR_IW-1:0] csr_index,
   input logic [gmt_pkg::CSR_DW-1:0] csr_wdata
);

   import gmt_pkg::*;

   logic accept;
   logic csr_seen;

   assign accept   = start && !busy;
   assign csr_seen = csr_we && (csr_index != REG_SELF || csr_wdata != '0);

   `GMT_ASSERT_RESET(a_reset_idle, !busy && !rsp_valid)
   `GMT_ASSERT_NEXT(a_tick_no_busy, accept && req_item.op == OP_TICK, !busy)
   `GMT_ASSERT_NEXT(a_op_goes_busy,
      accept && req_item.op != OP_TICK && req_item.op != OP_NOP, busy)
   `GMT_ASSERT_NEXT(a_last_ends_burst, rsp_valid && rsp_item.is_last, !rsp_valid)
   `GMT_ASSERT_NOW(a_absent_is_single, rsp_valid && !rsp_item.present,
      rsp_item.is_last || csr_seen)

endmodule

bind gossip_membership_table gmt_checker u_gmt_checker (.*);
